// ===== src/atapio_pkg.sv =====
// Shared types and constants for the ATA PIO disk device core.
// No dependencies; imported by the core, the medium and the task-file modules.
package atapio_pkg;

  localparam int unsigned SECTOR_BITS_DEF = 10;

  localparam int unsigned WORDS_PER_SECTOR_BITS = 8;
  localparam int unsigned SECTOR_TOTAL_W = 11;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned LBA_W = 28;

  // configuration register indexes
  localparam logic CFG_SECTOR_TOTAL = 1'b0;
  localparam logic CFG_DRIVE_PRESENT = 1'b1;

  // access kind
  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    TF_DATA     = 3'd0,
    TF_ERROR    = 3'd1,
    TF_COUNT    = 3'd2,
    TF_LBA_LOW  = 3'd3,
    TF_LBA_MID  = 3'd4,
    TF_LBA_HIGH = 3'd5,
    TF_SELECT   = 3'd6,
    TF_STATUS   = 3'd7
  } tf_reg_e;

  typedef enum logic [1:0] {
    XK_IDLE  = 2'd0,
    XK_IDENT = 2'd1,
    XK_READ  = 2'd2,
    XK_WRITE = 2'd3
  } xfer_e;

  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
  localparam logic [7:0] CMD_READ_PIO = 8'h20;
  localparam logic [7:0] CMD_WRITE_PIO = 8'h30;

  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_RDY = 8'h40;
  localparam logic [7:0] ER_ABRT = 8'h04;
  localparam logic [7:0] ER_IDNF = 8'h10;

  localparam logic [7:0] SELECT_RESET = 8'hA0;
  localparam int unsigned SELECT_SLAVE_BIT = 4;

  localparam logic [7:0] ID_WORD_TOTAL = 8'd60;
  localparam logic [7:0] LAST_WORD = 8'hFF;
  localparam logic [8:0] FULL_COUNT = 9'd256;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic        from_mem;
    logic [15:0] data;
  } rd_t;

endpackage

// ===== src/atapio_req_if.sv =====
// Request channel of the ATA PIO disk core: one task-file access per word.
// Standalone valid/ready interface; no dependencies.
interface atapio_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [2:0]  reg_index;
  logic [15:0] write_data;

  modport source (output valid, output mode, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input mode, input reg_index, input write_data,
                output ready);
endinterface

// ===== src/atapio_rsp_if.sv =====
// Response channel of the ATA PIO disk core: one read_data word per access.
// Standalone valid/ready interface; no dependencies.
interface atapio_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

// ===== src/ata_pio_disk_device_core.sv =====
// Top level of the ATA PIO disk device core: task-file logic, medium RAM, output pipe.
// Depends on atapio_pkg, atapio_req_if, atapio_rsp_if, atapio_taskfile, atapio_medium.

// Behaves as an LBA28 master drive seen from the task-file bus. Every request
// word is one register access (read or write) and yields exactly one response
// word: the register or data word read, or zero for writes. The core accepts
// one access per clock while ready is high. Stage 1 and the sector RAM's
// registered read take the access when it is accepted; the output register
// takes the word from them as soon as it is free. Under back-pressure
// on the response side the core holds at most two words (stage 1 and the
// output register) before the request side drops ready. The sector
// medium holds 256 << SECTOR_BITS 16-bit words and is not cleared at reset:
// a sector must be written before it is read back. Configuration writes
// (sector total, drive present) go straight into flops; the user must make
// them only while no access is in flight, the block does not enforce it.
module ata_pio_disk_device_core
  import atapio_pkg::*;
#(
  parameter int unsigned SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  atapio_req_if.sink            req_i,
  atapio_rsp_if.source          rsp_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = SECTOR_BITS + WORDS_PER_SECTOR_BITS;

  logic acc;
  logic out_free;
  rd_t rd;
  mem_ctl_t mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [15:0] mem_wdata, mem_rdata;

  // stage 1: access decoded, medium read in flight
  logic s1_valid_q, s1_valid_d;
  logic s1_sel_q;
  logic [15:0] s1_val_q;
  // output register
  logic rsp_valid_q, rsp_valid_d;
  logic [15:0] rsp_data_q;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || out_free;
  assign acc = req_i.valid && req_i.ready;

  atapio_taskfile #(
    .SECTOR_BITS(SECTOR_BITS)
  ) u_taskfile (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .mode_i       (req_i.mode),
    .reg_index_i  (req_i.reg_index),
    .write_data_i (req_i.write_data),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rd_o         (rd),
    .mem_ctl_o    (mem_ctl),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata)
  );

  atapio_medium #(
    .SECTOR_BITS(SECTOR_BITS)
  ) u_medium (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_valid_q && out_free) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (s1_valid_q && out_free) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload: RAM read data holds while stage 1 is stalled (no new read issued)
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_sel_q <= rd.from_mem;
      s1_val_q <= rd.data;
    end
    if (s1_valid_q && out_free) begin
      rsp_data_q <= s1_sel_q ? mem_rdata : s1_val_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.read_data = rsp_data_q;

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_valid_q)
    else $error("accepted word lost before stage 1");

  a_mem_read_tagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.re |=> (s1_valid_q && s1_sel_q))
    else $error("medium read not tracked by stage 1");

  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rsp_o.read_data)))
    else $error("response word dropped or changed while stalled");

endmodule

// ===== src/atapio_medium.sv =====
// Sector medium: single-port synchronous RAM with a registered read.
// Depends on atapio_pkg for the memory control struct.
module atapio_medium
  import atapio_pkg::*;
#(
  parameter int unsigned SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic                                   clk_i,
  input  mem_ctl_t                               ctl_i,
  input  logic [SECTOR_BITS+WORDS_PER_SECTOR_BITS-1:0] addr_i,
  input  logic [15:0]                            wdata_i,
  output logic [15:0]                            rdata_o
);

  localparam int unsigned AW = SECTOR_BITS + WORDS_PER_SECTOR_BITS;
  localparam int unsigned DEPTH = 2 ** AW;

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/atapio_taskfile.sv =====
// Task-file registers, command decode and transfer sequencing.
// Depends on atapio_pkg; drives the medium RAM request.
module atapio_taskfile
  import atapio_pkg::*;
#(
  parameter int unsigned SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic                      mode_i,
  input  logic [2:0]                reg_index_i,
  input  logic [15:0]               write_data_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  output rd_t                       rd_o,
  output mem_ctl_t                  mem_ctl_o,
  output logic [SECTOR_BITS+WORDS_PER_SECTOR_BITS-1:0] mem_addr_o,
  output logic [15:0]               mem_wdata_o
);

  localparam int unsigned MEDIUM_SECTORS = 2 ** SECTOR_BITS;
  localparam int unsigned SUM_W = LBA_W + 1;

  logic [SECTOR_TOTAL_W-1:0] sector_total_q, sector_total_d;
  logic present_q, present_d;
  logic [7:0] count_q, count_d, lba_lo_q, lba_lo_d, lba_mid_q, lba_mid_d;
  logic [7:0] lba_hi_q, lba_hi_d, select_q, select_d;
  logic [7:0] error_q, error_d, status_q, status_d;
  xfer_e xfer_q, xfer_d;
  logic [7:0] word_q, word_d;
  logic [8:0] left_q, left_d;
  logic [LBA_W-1:0] tlba_q, tlba_d;

  tf_reg_e tf_reg;
  logic [7:0] wbyte;
  logic drive_on;
  logic adv;
  logic [LBA_W-1:0] cmd_lba;
  logic [8:0] cmd_cnt;
  logic [SUM_W-1:0] cmd_end, limit;
  logic range_err;

  assign tf_reg = tf_reg_e'(reg_index_i);
  assign wbyte = write_data_i[7:0];
  assign drive_on = present_q && !select_q[SELECT_SLAVE_BIT];

  assign cmd_lba = {select_q[3:0], lba_hi_q, lba_mid_q, lba_lo_q};
  assign cmd_cnt = (count_q == 8'd0) ? FULL_COUNT : {1'b0, count_q};
  assign cmd_end = {1'b0, cmd_lba} + SUM_W'(cmd_cnt);
  // usable total saturates at the medium size
  assign limit = (SUM_W'(sector_total_q) > SUM_W'(MEDIUM_SECTORS)) ?
                 SUM_W'(MEDIUM_SECTORS) : SUM_W'(sector_total_q);
  assign range_err = cmd_end > limit;

  // a data word moves this access
  always_comb begin
    adv = 1'b0;
    if (acc_i && tf_reg == TF_DATA) begin
      if (mode_i == MODE_WRITE) begin
        adv = (xfer_q == XK_WRITE);
      end else begin
        adv = (xfer_q == XK_IDENT) || (xfer_q == XK_READ);
      end
    end
  end

  // next state
  always_comb begin
    sector_total_d = sector_total_q;
    present_d = present_q;
    count_d = count_q;
    lba_lo_d = lba_lo_q;
    lba_mid_d = lba_mid_q;
    lba_hi_d = lba_hi_q;
    select_d = select_q;
    error_d = error_q;
    status_d = status_q;
    xfer_d = xfer_q;
    word_d = word_q;
    left_d = left_q;
    tlba_d = tlba_q;

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_SECTOR_TOTAL) begin
        sector_total_d = cfg_wdata_i[SECTOR_TOTAL_W-1:0];
      end else begin
        present_d = cfg_wdata_i[0];
      end
    end

    if (adv) begin
      word_d = word_q + 8'd1;
      if (word_q == LAST_WORD) begin
        if (xfer_q == XK_IDENT) begin
          xfer_d = XK_IDLE;
          status_d = ST_RDY;
        end else begin
          tlba_d = tlba_q + LBA_W'(1);
          left_d = left_q - 9'd1;
          if (left_q == 9'd1) begin
            xfer_d = XK_IDLE;
            status_d = ST_RDY;
          end
        end
      end
    end

    if (acc_i && mode_i == MODE_WRITE) begin
      case (tf_reg)
        TF_COUNT:    count_d = wbyte;
        TF_LBA_LOW:  lba_lo_d = wbyte;
        TF_LBA_MID:  lba_mid_d = wbyte;
        TF_LBA_HIGH: lba_hi_d = wbyte;
        TF_SELECT:   select_d = wbyte;
        TF_STATUS: begin
          if (drive_on) begin
            xfer_d = XK_IDLE;
            word_d = 8'd0;
            left_d = 9'd0;
            error_d = 8'd0;
            if (wbyte == CMD_IDENTIFY) begin
              xfer_d = XK_IDENT;
              status_d = ST_RDY | ST_DRQ;
            end else if (wbyte != CMD_READ_PIO && wbyte != CMD_WRITE_PIO) begin
              error_d = ER_ABRT;
              status_d = ST_RDY | ST_ERR;
            end else if (range_err) begin
              error_d = ER_IDNF;
              status_d = ST_RDY | ST_ERR;
            end else begin
              xfer_d = (wbyte == CMD_READ_PIO) ? XK_READ : XK_WRITE;
              tlba_d = cmd_lba;
              left_d = cmd_cnt;
              status_d = ST_RDY | ST_DRQ;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs: register value and medium request
  always_comb begin
    rd_o = '0;
    mem_ctl_o = '0;
    mem_addr_o = {tlba_q[SECTOR_BITS-1:0], word_q};
    mem_wdata_o = write_data_i;
    if (acc_i && mode_i == MODE_WRITE) begin
      mem_ctl_o.we = adv;
    end else if (acc_i) begin
      case (tf_reg)
        TF_DATA: begin
          if (xfer_q == XK_READ) begin
            rd_o.from_mem = 1'b1;
            mem_ctl_o.re = 1'b1;
          end else if (xfer_q == XK_IDENT && word_q == ID_WORD_TOTAL) begin
            rd_o.data = 16'(sector_total_q);
          end
          // word 61 carries the high half of the total, always zero here
        end
        TF_ERROR:    rd_o.data = {8'd0, error_q};
        TF_COUNT:    rd_o.data = {8'd0, count_q};
        TF_LBA_LOW:  rd_o.data = {8'd0, lba_lo_q};
        TF_LBA_MID:  rd_o.data = {8'd0, lba_mid_q};
        TF_LBA_HIGH: rd_o.data = {8'd0, lba_hi_q};
        TF_SELECT:   rd_o.data = {8'd0, select_q};
        TF_STATUS:   rd_o.data = drive_on ? {8'd0, status_q} : 16'd0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_total_q <= SECTOR_TOTAL_W'(1024);
      present_q <= 1'b1;
      count_q <= 8'd0;
      lba_lo_q <= 8'd0;
      lba_mid_q <= 8'd0;
      lba_hi_q <= 8'd0;
      select_q <= SELECT_RESET;
      error_q <= 8'd0;
      status_q <= ST_RDY;
      xfer_q <= XK_IDLE;
      word_q <= 8'd0;
      left_q <= 9'd0;
      tlba_q <= '0;
    end else begin
      sector_total_q <= sector_total_d;
      present_q <= present_d;
      count_q <= count_d;
      lba_lo_q <= lba_lo_d;
      lba_mid_q <= lba_mid_d;
      lba_hi_q <= lba_hi_d;
      select_q <= select_d;
      error_q <= error_d;
      status_q <= status_d;
      xfer_q <= xfer_d;
      word_q <= word_d;
      left_q <= left_d;
      tlba_q <= tlba_d;
    end
  end

  a_drq_tracks_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((xfer_q != XK_IDLE) == ((status_q & ST_DRQ) != 8'd0)))
    else $error("DRQ out of step with transfer state");

  a_sectors_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer_q == XK_READ || xfer_q == XK_WRITE) |-> (left_q != 9'd0))
    else $error("sector transfer running with no sectors left");

  a_mem_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.we && mem_ctl_o.re))
    else $error("medium read and write in the same cycle");

endmodule
